// ----- sv/pdm_pkg.sv -----
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types, constants and helpers for the pairwise distance matrix unit.
// ----------------------------------------------------------------------------
package pdm_pkg;

  localparam int unsigned MAX_ATOMS_DEF = 64;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned ATOM_W     = 3 * COORD_W;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned SUM_W      = SQ_W;
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DIST_W     = 25;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned STEP_W     = $clog2(ROOT_STEPS);
  localparam int unsigned MUL_STEPS  = 4;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(64);

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
  } atom_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  column_index;
    logic [DIST_W-1:0] distance;
    logic              last_of_run;
    logic              conformer_end;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_RINIT,
    ST_ROOT,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic  load_atom;
    logic  rd_en;
    logic  diff_en;
    logic  mul_en;
    axis_e mul_sel;
    logic  acc_ld;
    logic  acc_add;
    logic  root_init;
    logic  root_step;
    logic  out_load;
    logic  out_last;
    logic  out_conf_end;
  } pdm_cmd_t;

  typedef struct packed {
    logic out_free;
  } pdm_sts_t;

  // |a - b| of two signed coordinates, one bit wider than a coordinate
  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

// ----- sv/pairwise_distance_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// pairwise_distance_matrix_unit
// Streaming 3-D distance matrix: stores each atom and emits its distances to
// all stored atoms of the conformer, itself included, lower triangle order.
//
//   channel | dir | handshake               | beat
//   --------+-----+-------------------------+-------------------------------
//   cfg     | in  | cfg_valid_i/cfg_ready_o | atom_count, 7 bits
//   in      | in  | in_valid_i/in_ready_o   | atom_in_t (x, y, z Q11.12)
//   out     | out | out_valid_o/out_ready_i | result_t (row, col, dist, flags)
//
// Each distance runs through read, difference, three squares on one
// shared multiplier with accumulate, and a 25-step bit-serial square root.
// An atom at row j occupies the unit for j+1 distances plus any output stalls.
// in_ready_o is high only while no atom is in work; a pending result in the
// output register does not hold off the next atom. No clearing pass after reset.
// ----------------------------------------------------------------------------
module pairwise_distance_matrix_unit #(
  parameter int unsigned MAX_ATOMS = pdm_pkg::MAX_ATOMS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pdm_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pdm_pkg::atom_in_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pdm_pkg::result_t          out_data_o
);
  import pdm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ATOMS);

  pdm_cmd_t      cmd;
  pdm_sts_t      sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] row;
  logic [AW-1:0] col;

  assign cfg_ready_o = 1'b1;

  pdm_ctrl #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr),
    .row_o       (row),
    .col_o       (col)
  );

  pdm_datapath #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .row_i       (row),
    .col_i       (col),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/pdm_ram.sv -----
// ----------------------------------------------------------------------------
// pdm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pdm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdm_ctrl
// Sequencer: row/column/position counters, atom count register and the
// per-distance command schedule for the datapath.
// ----------------------------------------------------------------------------
module pdm_ctrl #(
  parameter int unsigned MAX_ATOMS = pdm_pkg::MAX_ATOMS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [pdm_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pdm_pkg::pdm_sts_t            sts_i,
  output pdm_pkg::pdm_cmd_t            cmd_o,
  output logic [$clog2(MAX_ATOMS)-1:0] wr_addr_o,
  output logic [$clog2(MAX_ATOMS)-1:0] rd_addr_o,
  output logic [$clog2(MAX_ATOMS)-1:0] row_o,
  output logic [$clog2(MAX_ATOMS)-1:0] col_o
);
  import pdm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ATOMS);
  localparam int unsigned CW = (CNT_W > $clog2(MAX_ATOMS + 1)) ? CNT_W
                                                               : $clog2(MAX_ATOMS + 1);

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     row_q, row_d;
  logic [AW-1:0]     col_q, col_d;
  logic              rlast_q, rlast_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CW-1:0]     cnt_ext;
  logic [CW-1:0]     eff_n;
  logic [AW-1:0]     j_sel;

  // effective count: zero acts as one, large values saturate
  assign cnt_ext = CW'(count_q);
  assign eff_n   = (count_q == '0)              ? CW'(1) :
                   (cnt_ext > CW'(MAX_ATOMS))   ? CW'(MAX_ATOMS) : cnt_ext;
  // position left beyond a lowered count restarts the conformer
  assign j_sel   = (CW'(pos_q) >= eff_n) ? '0 : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= CNT_RESET;
      pos_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      rlast_q <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      row_q   <= row_d;
      col_q   <= col_d;
      rlast_q <= rlast_d;
      step_q  <= step_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    row_d      = row_q;
    col_d      = col_q;
    rlast_d    = rlast_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_atom = 1'b1;
          row_d   = j_sel;
          col_d   = '0;
          rlast_d = (CW'(j_sel) == CW'(eff_n - CW'(1)));
          pos_d   = (CW'(CW'(j_sel) + CW'(1)) >= eff_n) ? '0 : AW'(j_sel + AW'(1));
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        step_d        = '0;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        // squares go out one per cycle; the accumulator takes each one from the product register
        cmd_o.mul_en  = (step_q < STEP_W'(MUL_STEPS - 1));
        cmd_o.mul_sel = (step_q == STEP_W'(1)) ? AXIS_Y :
                        (step_q == STEP_W'(2)) ? AXIS_Z : AXIS_X;
        cmd_o.acc_ld  = (step_q == STEP_W'(1));
        cmd_o.acc_add = (step_q >= STEP_W'(2));
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_RINIT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_RINIT: begin
        cmd_o.root_init = 1'b1;
        step_d          = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_EMIT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_last     = (col_q == row_q);
          cmd_o.out_conf_end = (col_q == row_q) && rlast_q;
          if (col_q == row_q) begin
            state_d = ST_IDLE;
          end else begin
            col_d   = col_q + AW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign wr_addr_o = j_sel;
  assign rd_addr_o = col_q;
  assign row_o     = row_q;
  assign col_o     = col_q;

endmodule

// ----- sv/pdm_datapath.sv -----
// ----------------------------------------------------------------------------
// pdm_datapath
// Atom store, difference/square/accumulate path, bit-serial integer square
// root and the output register.
// ----------------------------------------------------------------------------
module pdm_datapath #(
  parameter int unsigned MAX_ATOMS = pdm_pkg::MAX_ATOMS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pdm_pkg::pdm_cmd_t            cmd_i,
  output pdm_pkg::pdm_sts_t            sts_o,
  input  pdm_pkg::atom_in_t            in_data_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] wr_addr_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] row_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] col_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pdm_pkg::result_t             out_data_o
);
  import pdm_pkg::*;

  atom_in_t            new_q;
  logic [ATOM_W-1:0]   rd_data;
  atom_in_t            old_atom;
  logic [DIFF_W-1:0]   ax_q, ay_q, az_q;
  logic [DIFF_W-1:0]   mul_op;
  logic [SQ_W-1:0]     prod_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    rad_q;
  logic [ROOT_W-1:0]   rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic                fits;
  result_t             out_q;
  logic                out_valid_q;

  pdm_ram #(
    .WIDTH (ATOM_W),
    .DEPTH (MAX_ATOMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_atom),
    .waddr_i (wr_addr_i),
    .wdata_i (in_data_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  assign old_atom = atom_in_t'(rd_data);

  always_comb begin
    case (cmd_i.mul_sel)
      AXIS_Y:  mul_op = ay_q;
      AXIS_Z:  mul_op = az_q;
      default: mul_op = ax_q;
    endcase
  end

  // restoring root: two radicand bits in, one root bit out per cycle
  assign rem_sh = {rem_q, rad_q[SUM_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_atom) begin
      new_q <= in_data_i;
    end
    if (cmd_i.diff_en) begin
      ax_q <= abs_diff(new_q.x_coord, old_atom.x_coord);
      ay_q <= abs_diff(new_q.y_coord, old_atom.y_coord);
      az_q <= abs_diff(new_q.z_coord, old_atom.z_coord);
    end
    if (cmd_i.mul_en) begin
      prod_q <= SQ_W'(mul_op) * SQ_W'(mul_op);
    end
    if (cmd_i.acc_ld) begin
      sum_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      sum_q <= sum_q + prod_q;
    end
    if (cmd_i.root_init) begin
      rad_q  <= sum_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[SUM_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= ROOT_W'(rem_sh - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= ROOT_W'(rem_sh);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_q.row_index     <= IDX_W'(row_i);
      out_q.column_index  <= IDX_W'(col_i);
      out_q.distance      <= DIST_W'(root_q);
      out_q.last_of_run   <= cmd_i.out_last;
      out_q.conformer_end <= cmd_i.out_conf_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ----- sv/pdm_checker.sv -----
// ----------------------------------------------------------------------------
// pdm_checker
// Port-level checks for the pairwise distance matrix unit.
// ----------------------------------------------------------------------------
module pdm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input pdm_pkg::result_t          out_data_o
);

  // a held result beat does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // an accepted atom keeps the unit busy for at least one distance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after an atom");

  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_run |->
      out_data_o.column_index == out_data_o.row_index)
    else $error("run end off the diagonal");

  a_lower_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.column_index <= out_data_o.row_index)
    else $error("column above row");

  a_conf_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.conformer_end |-> out_data_o.last_of_run)
    else $error("conformer end without run end");

endmodule

bind pairwise_distance_matrix_unit pdm_checker u_pdm_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pairwise_distance_matrix_unit. A directed table walks
// extremes and atom_count corner cases (zero, saturation, lowered and raised
// mid-conformer), then random phases of conformers at random counts follow.
// Every distance beat is checked field by field against a local model of the
// atom store, with bursty atom input and a patterned output stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_ATOMS = 320;
  localparam int unsigned PLAN_LEN = 23;
  localparam logic [COORD_W-1:0] MINC = 24'h800000;
  localparam logic [COORD_W-1:0] MAXC = 24'h7FFFFF;

  typedef struct packed {
    bit                 is_cfg;
    logic [CNT_W-1:0]   count;
    bit                 typed;   // want_dist holds the known column-0 distance
    logic [DIST_W-1:0]  want_dist;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } plan_row_t;

  // is_cfg, count, typed, want_dist, x, y, z
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, 7'd0,   1'b1, 25'd0,        MINC,      MINC,      MINC},
    '{1'b0, 7'd0,   1'b1, 25'd29058988, MAXC,      MAXC,      MAXC},
    '{1'b0, 7'd0,   1'b0, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b0, 25'd0,        MAXC,      MINC,      24'h0},
    '{1'b0, 7'd0,   1'b0, 25'd0,        MINC,      MAXC,      MAXC},
    '{1'b0, 7'd0,   1'b0, 25'd0,        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
    '{1'b1, 7'd0,   1'b0, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b1, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b1, 25'd0,        24'h003000, 24'h004000, 24'h0},
    '{1'b1, 7'd127, 1'b0, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b1, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b1, 25'd20480,    24'h003000, 24'h004000, 24'h0},
    '{1'b0, 7'd0,   1'b1, 25'd4096,     24'h0,     24'h0,     24'h001000},
    '{1'b1, 7'd3,   1'b0, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b0, 25'd0,        24'h000001, 24'h000002, 24'h000003},
    '{1'b0, 7'd0,   1'b0, 25'd0,        24'hFFFFFB, 24'h000007, MAXC},
    '{1'b0, 7'd0,   1'b0, 25'd0,        24'h555555, 24'hAAAAAA, 24'h0F0F0F},
    '{1'b0, 7'd0,   1'b0, 25'd0,        24'hA5A5A5, 24'h5A5A5A, 24'hFFFFFF},
    '{1'b1, 7'd64,  1'b0, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b0, 25'd0,        24'h123456, 24'hFEDCBA, 24'h000800},
    '{1'b0, 7'd0,   1'b1, 25'd0,        24'hA5A5A5, 24'h5A5A5A, 24'hFFFFFF},
    '{1'b1, 7'd1,   1'b0, 25'd0,        24'h0,     24'h0,     24'h0},
    '{1'b0, 7'd0,   1'b1, 25'd0,        24'h7FF000, 24'h800FFF, 24'h000FFF}
  };

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  atom_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  result_t          out_data;

  // local model state
  atom_in_t         stored_atoms [MAX_ATOMS_DEF];
  int unsigned      atom_pos = 0;
  logic [CNT_W-1:0] count_reg = CNT_RESET;
  result_t          pair_q [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int          cluster_x = 0;
  int          cluster_y = 0;
  int          cluster_z = 0;

  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  logic [2:0]  stall_tick = '0;

  pairwise_distance_matrix_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    if (mismatches < 40)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned atoms_per_conformer();
    if (count_reg == 0)
      return 1;
    if (count_reg > MAX_ATOMS_DEF)
      return MAX_ATOMS_DEF;
    return 32'(count_reg);
  endfunction

  // floor square root, built MSB first
  function automatic logic [DIST_W-1:0] floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v)
        r = t;
    end
    return r[DIST_W-1:0];
  endfunction

  // store the atom and queue its distances to columns 0..row
  task automatic compute_pairs(input atom_in_t a, input bit typed,
                               input logic [DIST_W-1:0] typed_dist);
    int unsigned n;
    int unsigned row;
    longint dx;
    longint dy;
    longint dz;
    result_t r;
    n = atoms_per_conformer();
    row = (atom_pos >= n) ? 0 : atom_pos;
    stored_atoms[row] = a;
    for (int unsigned col = 0; col <= row; col++) begin
      dx = longint'($signed(a.x_coord)) - longint'($signed(stored_atoms[col].x_coord));
      dy = longint'($signed(a.y_coord)) - longint'($signed(stored_atoms[col].y_coord));
      dz = longint'($signed(a.z_coord)) - longint'($signed(stored_atoms[col].z_coord));
      r.row_index     = IDX_W'(row);
      r.column_index  = IDX_W'(col);
      r.distance      = floor_root(longint'(dx * dx + dy * dy + dz * dz));
      r.last_of_run   = (col == row);
      r.conformer_end = (col == row) && (row == n - 1);
      if (typed && col == 0)
        r.distance = typed_dist;
      pair_q.insert(pair_q.size(), r);
    end
    atom_pos = (row + 1 >= n) ? 0 : row + 1;
  endtask

  // bursts of random length; a gap of zero keeps valid high across bursts
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_atom(input atom_in_t a, input bit typed,
                           input logic [DIST_W-1:0] typed_dist);
    in_data  <= a;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    compute_pairs(a, typed, typed_dist);
    pace_sender();
  endtask

  // only with nothing in flight
  task automatic write_count(input logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (pair_q.size() != 0) @(posedge clk_i);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_reg = v;
  endtask

  function automatic logic [COORD_W-1:0] corner_coord();
    case ($urandom_range(0, 3))
      0: return MINC;
      1: return MAXC;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic atom_in_t pick_atom();
    atom_in_t a;
    int unsigned n;
    n = atoms_per_conformer();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        a.x_coord = COORD_W'($urandom);
        a.y_coord = COORD_W'($urandom);
        a.z_coord = COORD_W'($urandom);
      end
      4, 5, 6: begin
        // molecule-like cluster, +-20 A around the phase center
        a.x_coord = COORD_W'(cluster_x + int'($urandom_range(0, 163840)) - 81920);
        a.y_coord = COORD_W'(cluster_y + int'($urandom_range(0, 163840)) - 81920);
        a.z_coord = COORD_W'(cluster_z + int'($urandom_range(0, 163840)) - 81920);
      end
      7: begin
        a.x_coord = corner_coord();
        a.y_coord = corner_coord();
        a.z_coord = corner_coord();
      end
      8: begin
        // repeat an atom already in this conformer: zero distance
        if (atom_pos > 0 && atom_pos < n) begin
          a = stored_atoms[$urandom_range(0, atom_pos - 1)];
        end else begin
          a.x_coord = COORD_W'($urandom);
          a.y_coord = COORD_W'($urandom);
          a.z_coord = COORD_W'($urandom);
        end
      end
      default: begin
        a.x_coord = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
        a.y_coord = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
        a.z_coord = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
      end
    endcase
    return a;
  endfunction

  // distance sink: own stall pattern, check against the oldest queued pair
  always @(posedge clk_i) begin : sink
    result_t want;
    if (out_valid && out_ready) begin
      if (pair_q.size() == 0) begin
        report("unexpected beat, distance", out_data.distance, 0);
      end else begin
        want = pair_q.pop_front();
        if (out_data.row_index != want.row_index)
          report("row_index", out_data.row_index, want.row_index);
        if (out_data.column_index != want.column_index)
          report("column_index", out_data.column_index, want.column_index);
        if (out_data.distance != want.distance)
          report("distance", out_data.distance, want.distance);
        if (out_data.last_of_run != want.last_of_run)
          report("last_of_run", out_data.last_of_run, want.last_of_run);
        if (out_data.conformer_end != want.conformer_end)
          report("conformer_end", out_data.conformer_end, want.conformer_end);
      end
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_tick >= 3'd6);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin : stim
    int unsigned sent;
    int unsigned items;
    int unsigned sel;
    int unsigned big_left;
    bit first_phase;
    logic [CNT_W-1:0] cnt;
    sent = 0;
    big_left = 2;
    first_phase = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg)
        write_count(PLAN[i].count);
      else
        send_atom('{x_coord: PLAN[i].x, y_coord: PLAN[i].y, z_coord: PLAN[i].z},
                  PLAN[i].typed, PLAN[i].want_dist);
    end

    while (sent < RANDOM_ATOMS) begin
      sel = $urandom_range(0, 15);
      if (first_phase || (sel == 0 && big_left > 0)) begin
        // full-size conformer, up to four atoms past the wrap
        cnt = ($urandom_range(0, 1) == 0) ? CNT_W'(64) : CNT_W'($urandom_range(65, 127));
        items = $urandom_range(64, 68);
        big_left--;
      end else if (sel == 1) begin
        cnt = '0;
        items = $urandom_range(1, 6);
      end else if (sel == 2) begin
        cnt = CNT_W'(1);
        items = $urandom_range(1, 6);
      end else if (sel <= 5) begin
        cnt = CNT_W'($urandom_range(9, 24));
        items = $urandom_range(1, 40);
      end else begin
        cnt = CNT_W'($urandom_range(2, 8));
        items = $urandom_range(1, 24);
      end
      first_phase = 1'b0;
      cluster_x = int'($urandom_range(0, 16000000)) - 8000000;
      cluster_y = int'($urandom_range(0, 16000000)) - 8000000;
      cluster_z = int'($urandom_range(0, 16000000)) - 8000000;
      write_count(cnt);
      repeat (items) begin
        send_atom(pick_atom(), 1'b0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (pair_q.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last one
    repeat (100) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
